/* rtl/wtpp_pkg.sv */
// Package for the windowed threshold peak picker: sizes, row and cell types,
// register indexes and controller states. Depends on nothing.
`default_nettype none

package wtpp_pkg;

  localparam int LANE_COUNT    = 8;
  localparam int WINDOW_MAX    = 64;
  localparam int ROWS_MAX      = 4096;
  localparam int PEAKS_MAX     = 64;
  localparam int SAMPLE_BITS   = 16;

  localparam int WIN_CFG_BITS  = 7;
  localparam int LANE_CFG_BITS = 4;
  localparam int AGE_BITS      = $clog2(WINDOW_MAX);
  localparam int ROW_BITS      = 13;
  localparam int PEAK_BITS     = 7;
  localparam int ADDR_BITS     = 3;
  localparam int DATA_BITS     = 32;

  localparam int GROUP_SIZE    = 8;
  localparam int GROUP_COUNT   = (WINDOW_MAX + GROUP_SIZE - 1) / GROUP_SIZE;

  // register index, taken from paddr[2]
  localparam logic REG_WINDOW_LENGTH = 1'b0;
  localparam logic REG_ACTIVE_LANES  = 1'b1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef sample_t [LANE_COUNT-1:0] row_t;

  typedef struct packed {
    row_t    samples;
    sample_t thr;
  } entry_t;

  typedef struct packed {
    logic                  shift;
    logic                  compare;
    row_t                  cand;
    logic [LANE_COUNT-1:0] qual;
  } cell_ctrl_t;

  typedef struct packed {
    logic [WIN_CFG_BITS-1:0]  window;
    logic [LANE_CFG_BITS-1:0] lanes;
    logic [AGE_BITS-1:0]      cand_age;
  } cfg_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SEL  = 5'b00010,
    ST_CMP  = 5'b00100,
    ST_RED  = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

endpackage

`default_nettype wire

/* rtl/wtpp_cell.sv */
// One window cell: holds a row and its threshold, passes it on when the
// chain shifts and flags a lane sample above the broadcast candidate.
// Depends on wtpp_pkg.
`default_nettype none

module wtpp_cell (
  input  wire logic                clk,
  input  wire wtpp_pkg::cell_ctrl_t ctrl,
  input  wire logic                in_window,
  input  wire wtpp_pkg::entry_t    prev_entry,
  output wtpp_pkg::entry_t         entry,
  output logic                     fail
);

  logic [wtpp_pkg::LANE_COUNT-1:0] above;
  logic                            fail_next;

  always_comb begin
    for (int l = 0; l < wtpp_pkg::LANE_COUNT; l++) begin
      above[l] = $signed(ctrl.cand[l]) < $signed(entry.samples[l]);
    end
    // only lanes that reach the threshold must dominate the window
    fail_next = in_window & (|(ctrl.qual & above));
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      entry <= prev_entry;
    end
    if (ctrl.compare) begin
      fail <= fail_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/wtpp_cfg_regs.sv */
// Configuration registers behind the APB-style port; hands the clamped
// window length, lane count and candidate age to the datapath. Depends on wtpp_pkg.
`default_nettype none

module wtpp_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [wtpp_pkg::ADDR_BITS-1:0] paddr,
  input  wire logic [wtpp_pkg::DATA_BITS-1:0] pwdata,
  output logic      [wtpp_pkg::DATA_BITS-1:0] prdata,
  output logic                                pready,
  output wtpp_pkg::cfg_t                      cfg
);

  logic [wtpp_pkg::WIN_CFG_BITS-1:0]  win_len;
  logic [wtpp_pkg::LANE_CFG_BITS-1:0] active_lanes;
  logic [wtpp_pkg::WIN_CFG_BITS-1:0]  win_eff;
  logic                               wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_len      <= wtpp_pkg::WIN_CFG_BITS'(16);
      active_lanes <= wtpp_pkg::LANE_CFG_BITS'(8);
    end else if (wr_en) begin
      unique case (paddr[2])
        wtpp_pkg::REG_WINDOW_LENGTH:
          win_len      <= pwdata[wtpp_pkg::WIN_CFG_BITS-1:0];
        wtpp_pkg::REG_ACTIVE_LANES:
          active_lanes <= pwdata[wtpp_pkg::LANE_CFG_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      wtpp_pkg::REG_WINDOW_LENGTH:
        prdata = wtpp_pkg::DATA_BITS'(win_len);
      wtpp_pkg::REG_ACTIVE_LANES:
        prdata = wtpp_pkg::DATA_BITS'(active_lanes);
      default:
        prdata = '0;
    endcase
  end

  // clamp: zero acts as one, oversize values saturate
  always_comb begin
    priority if (win_len == '0) begin
      win_eff = wtpp_pkg::WIN_CFG_BITS'(1);
    end else if (win_len > wtpp_pkg::WIN_CFG_BITS'(wtpp_pkg::WINDOW_MAX)) begin
      win_eff = wtpp_pkg::WIN_CFG_BITS'(wtpp_pkg::WINDOW_MAX);
    end else begin
      win_eff = win_len;
    end
    cfg.window = win_eff;
    if (active_lanes > wtpp_pkg::LANE_CFG_BITS'(wtpp_pkg::LANE_COUNT)) begin
      cfg.lanes = wtpp_pkg::LANE_CFG_BITS'(wtpp_pkg::LANE_COUNT);
    end else begin
      cfg.lanes = active_lanes;
    end
    cfg.cand_age = wtpp_pkg::AGE_BITS'((win_eff - wtpp_pkg::WIN_CFG_BITS'(1)) - (win_eff >> 1));
  end

endmodule

`default_nettype wire

/* rtl/windowed_threshold_peak_picker_core.sv */
// Windowed threshold peak picker: top level with the row of window cells,
// the candidate and reduction registers and the controller.
// Depends on wtpp_pkg, wtpp_cell and wtpp_cfg_regs.
//
// Usage:
//   Rows arrive on the sample channel (sample_0..7, row_threshold, last_row)
//   and are taken when sample_valid is high and sample_stall low. Results
//   leave on the result channel under result_valid / result_stall; a row
//   gives one result when it is a peak or ends a frame, otherwise none.
//   Each row passes through these steps in order: accept and shift into the
//   cell chain, latch the candidate, compare in every cell at once, reduce
//   the cell flags in groups of eight, then decide and load the output
//   register. The next row is taken only after the controller has left the
//   decide step and returned to idle.
//   A waiting result does not block a new row; only a second result that
//   finds the output register still stalled holds in its decide cycle.
//   Reset empties the output register, clears the row and peak counters and
//   restores the window length to 16 and the lane count to 8. The window
//   contents need no clearing: only rows of the current frame are compared.
`default_nettype none

module windowed_threshold_peak_picker_core (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [wtpp_pkg::ADDR_BITS-1:0]   paddr,
  input  wire logic [wtpp_pkg::DATA_BITS-1:0]   pwdata,
  output logic      [wtpp_pkg::DATA_BITS-1:0]   prdata,
  output logic                                  pready,
  input  wire logic                             sample_valid,
  output logic                                  sample_stall,
  input  wire logic signed [wtpp_pkg::SAMPLE_BITS-1:0] sample_0,
  input  wire logic signed [wtpp_pkg::SAMPLE_BITS-1:0] sample_1,
  input  wire logic signed [wtpp_pkg::SAMPLE_BITS-1:0] sample_2,
  input  wire logic signed [wtpp_pkg::SAMPLE_BITS-1:0] sample_3,
  input  wire logic signed [wtpp_pkg::SAMPLE_BITS-1:0] sample_4,
  input  wire logic signed [wtpp_pkg::SAMPLE_BITS-1:0] sample_5,
  input  wire logic signed [wtpp_pkg::SAMPLE_BITS-1:0] sample_6,
  input  wire logic signed [wtpp_pkg::SAMPLE_BITS-1:0] sample_7,
  input  wire logic signed [wtpp_pkg::SAMPLE_BITS-1:0] row_threshold,
  input  wire logic                             last_row,
  output logic                                  result_valid,
  input  wire logic                             result_stall,
  output logic                                  peak_found,
  output logic      [wtpp_pkg::ROW_BITS-1:0]    peak_location,
  output logic      [wtpp_pkg::PEAK_BITS-1:0]   peak_total,
  output logic                                  frame_end,
  output logic                                  limit_hit
);

  localparam int W  = wtpp_pkg::WINDOW_MAX;
  localparam int G  = wtpp_pkg::GROUP_COUNT;
  localparam int GS = wtpp_pkg::GROUP_SIZE;

  wtpp_pkg::cfg_t      cfg;
  wtpp_pkg::state_t    state, state_next;
  wtpp_pkg::entry_t    new_entry;
  wtpp_pkg::entry_t    chain [W];
  wtpp_pkg::entry_t    cand_sel;
  wtpp_pkg::cell_ctrl_t cell_ctrl;

  logic [W-1:0]                      win_mask;
  logic [W-1:0]                      cell_fail;
  logic [G-1:0]                      group_fail;
  logic [G-1:0]                      group_fail_next;
  wtpp_pkg::row_t                    cand_row;
  logic [wtpp_pkg::LANE_COUNT-1:0]   qual;
  logic [wtpp_pkg::LANE_COUNT-1:0]   qual_next;

  logic [wtpp_pkg::ROW_BITS-1:0]     rows_seen;
  logic [wtpp_pkg::ROW_BITS-1:0]     rows_seen_next;
  logic [wtpp_pkg::PEAK_BITS-1:0]    peaks_found;
  logic [wtpp_pkg::PEAK_BITS-1:0]    peaks_after;
  logic                              eligible, eligible_next;
  logic                              last_q;
  logic                              accept, store_ok;
  logic                              found, need_result, out_busy, load_out;
  logic [wtpp_pkg::ROW_BITS-1:0]     loc;

  wtpp_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  always_comb begin
    new_entry.samples[0] = sample_0;
    new_entry.samples[1] = sample_1;
    new_entry.samples[2] = sample_2;
    new_entry.samples[3] = sample_3;
    new_entry.samples[4] = sample_4;
    new_entry.samples[5] = sample_5;
    new_entry.samples[6] = sample_6;
    new_entry.samples[7] = sample_7;
    new_entry.thr        = row_threshold;
  end

  assign sample_stall = (state != wtpp_pkg::ST_IDLE);
  assign accept       = sample_valid & ~sample_stall;
  assign store_ok     = (rows_seen < wtpp_pkg::ROW_BITS'(wtpp_pkg::ROWS_MAX));

  assign cell_ctrl.shift   = accept & store_ok;
  assign cell_ctrl.compare = (state == wtpp_pkg::ST_CMP);
  assign cell_ctrl.cand    = cand_row;
  assign cell_ctrl.qual    = qual;

  // cell k holds the row stored k rows before the newest one
  for (genvar k = 0; k < W; k++) begin : g_cell
    assign win_mask[k] = (wtpp_pkg::WIN_CFG_BITS'(k) < cfg.window);
    if (k == 0) begin : g_head
      wtpp_cell u_cell (
        .clk        (clk),
        .ctrl       (cell_ctrl),
        .in_window  (win_mask[k]),
        .prev_entry (new_entry),
        .entry      (chain[k]),
        .fail       (cell_fail[k])
      );
    end else begin : g_body
      wtpp_cell u_cell (
        .clk        (clk),
        .ctrl       (cell_ctrl),
        .in_window  (win_mask[k]),
        .prev_entry (chain[k-1]),
        .entry      (chain[k]),
        .fail       (cell_fail[k])
      );
    end
  end

  assign cand_sel = chain[cfg.cand_age];

  always_comb begin
    for (int l = 0; l < wtpp_pkg::LANE_COUNT; l++) begin
      qual_next[l] = (wtpp_pkg::LANE_CFG_BITS'(l) < cfg.lanes) &&
                     ($signed(cand_sel.samples[l]) >= $signed(cand_sel.thr));
    end
    for (int g = 0; g < G; g++) begin
      group_fail_next[g] = 1'b0;
      for (int j = 0; j < GS; j++) begin
        if (g * GS + j < W) begin
          group_fail_next[g] = group_fail_next[g] | cell_fail[g * GS + j];
        end
      end
    end
  end

  // candidate and reduction registers carry payload only
  always_ff @(posedge clk) begin
    if (state == wtpp_pkg::ST_SEL) begin
      cand_row <= cand_sel.samples;
      qual     <= qual_next;
    end
    if (state == wtpp_pkg::ST_RED) begin
      group_fail <= group_fail_next;
    end
  end

  assign rows_seen_next = rows_seen + wtpp_pkg::ROW_BITS'(1);
  assign eligible_next  = store_ok &&
                          (rows_seen_next >= wtpp_pkg::ROW_BITS'(cfg.window)) &&
                          (peaks_found < wtpp_pkg::PEAK_BITS'(wtpp_pkg::PEAKS_MAX));

  assign found       = eligible & (|qual) & ~(|group_fail);
  assign need_result = found | last_q;
  assign peaks_after = peaks_found + wtpp_pkg::PEAK_BITS'(found);
  assign out_busy    = result_valid & result_stall;
  assign load_out    = (state == wtpp_pkg::ST_DONE) & need_result & ~out_busy;
  assign loc         = rows_seen - wtpp_pkg::ROW_BITS'(cfg.window) + wtpp_pkg::ROW_BITS'(1) +
                       wtpp_pkg::ROW_BITS'(cfg.window >> 1);

  always_comb begin
    state_next = state;
    unique case (state)
      wtpp_pkg::ST_IDLE: if (accept) state_next = wtpp_pkg::ST_SEL;
      wtpp_pkg::ST_SEL:  state_next = wtpp_pkg::ST_CMP;
      wtpp_pkg::ST_CMP:  state_next = wtpp_pkg::ST_RED;
      wtpp_pkg::ST_RED:  state_next = wtpp_pkg::ST_DONE;
      wtpp_pkg::ST_DONE: begin
        // hold while a result is due and the previous one is still stalled
        if (!(need_result && out_busy)) state_next = wtpp_pkg::ST_IDLE;
      end
      default:           state_next = wtpp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= wtpp_pkg::ST_IDLE;
      rows_seen    <= '0;
      peaks_found  <= '0;
      eligible     <= 1'b0;
      last_q       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        eligible <= eligible_next;
        last_q   <= last_row;
        if (store_ok) begin
          rows_seen <= rows_seen_next;
        end
      end
      if ((state == wtpp_pkg::ST_DONE) && (state_next == wtpp_pkg::ST_IDLE)) begin
        if (last_q) begin
          rows_seen   <= '0;
          peaks_found <= '0;
        end else begin
          peaks_found <= peaks_after;
        end
      end
      if (load_out) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      peak_found    <= found;
      peak_location <= found ? loc : '0;
      peak_total    <= peaks_after;
      frame_end     <= last_q;
      limit_hit     <= (peaks_after >= wtpp_pkg::PEAK_BITS'(wtpp_pkg::PEAKS_MAX));
    end
  end

  a_total_bounded : assert property (@(posedge clk) disable iff (rst)
    result_valid |-> peak_total <= wtpp_pkg::PEAK_BITS'(wtpp_pkg::PEAKS_MAX))
    else $error("peak count beyond limit");

  a_peak_has_location : assert property (@(posedge clk) disable iff (rst)
    result_valid && peak_found |-> peak_location != '0)
    else $error("peak reported at row zero");

  a_result_from_done : assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == wtpp_pkg::ST_DONE))
    else $error("result loaded outside the decide cycle");

  a_no_overwrite : assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(peak_total) &&
                                     $stable(peak_location))
    else $error("stalled result overwritten");

endmodule

`default_nettype wire
